// File: rtl/rfpc_pkg.sv
// Shared constants, types and the CORDIC angle table of the robot-frame P controller.
package rfpc_pkg;

  // Field widths
  localparam int COORD_BITS  = 16;
  localparam int YAW_W       = 16;
  localparam int LIN_GAIN_W  = 24;
  localparam int ANG_GAIN_W  = 20;
  localparam int OUT_W       = 32;

  // CORDIC chain
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int ATAN_IDX_W    = 5;
  localparam int XY_W          = 33;  // Q1.30 vector plus gain growth and sign
  localparam int ZW            = 34;  // Q2.29 angle with headroom
  localparam int YAW_SHIFT     = 16;  // Q3.13 to Q2.29

  // Derived datapath widths
  localparam int ERR_W       = COORD_BITS + 1;
  localparam int DYAW_W      = YAW_W + 1;
  localparam int TURN_PROD_W = DYAW_W + ANG_GAIN_W + 1;
  localparam int TURN_SHIFT  = 13;
  localparam int TURN_W      = TURN_PROD_W - TURN_SHIFT;

  localparam logic signed [ZW-1:0]   ANG_HALF_PI     = ZW'(843314857);
  localparam logic signed [ZW-1:0]   ANG_PI          = ZW'(1686629713);
  localparam logic signed [XY_W-1:0] CORDIC_INV_GAIN = XY_W'(652032874);

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_LINEAR_GAIN  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ANGULAR_GAIN = 1'b1;
  localparam logic [LIN_GAIN_W-1:0] LIN_GAIN_RESET = LIN_GAIN_W'(6711);
  localparam logic [ANG_GAIN_W-1:0] ANG_GAIN_RESET = ANG_GAIN_W'(45875);

  typedef struct packed {
    logic [LIN_GAIN_W-1:0] linear_gain;
    logic [ANG_GAIN_W-1:0] angular_gain;
  } rfpc_cfg_t;

  // What travels down the CORDIC chain with each pose pair
  typedef struct packed {
    logic signed [XY_W-1:0]        x;
    logic signed [XY_W-1:0]        y;
    logic signed [ZW-1:0]          z;
    logic                          flip;
    logic signed [ERR_W-1:0]       ex;
    logic signed [ERR_W-1:0]       ey;
    logic signed [TURN_PROD_W-1:0] turn_prod;
  } rfpc_rot_t;

  // atan(2^-i) in Q2.29
  function automatic logic signed [ZW-1:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      5'd0:    a = ZW'(421657428);
      5'd1:    a = ZW'(248918915);
      5'd2:    a = ZW'(131521918);
      5'd3:    a = ZW'(66762579);
      5'd4:    a = ZW'(33510843);
      5'd5:    a = ZW'(16771758);
      5'd6:    a = ZW'(8387925);
      5'd7:    a = ZW'(4194219);
      5'd8:    a = ZW'(2097141);
      5'd9:    a = ZW'(1048575);
      5'd10:   a = ZW'(524288);
      5'd11:   a = ZW'(262144);
      5'd12:   a = ZW'(131072);
      5'd13:   a = ZW'(65536);
      5'd14:   a = ZW'(32768);
      5'd15:   a = ZW'(16384);
      5'd16:   a = ZW'(8192);
      5'd17:   a = ZW'(4096);
      5'd18:   a = ZW'(2048);
      5'd19:   a = ZW'(1024);
      5'd20:   a = ZW'(512);
      5'd21:   a = ZW'(256);
      5'd22:   a = ZW'(128);
      5'd23:   a = ZW'(64);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/rfpc_pose_if.sv
// Input channel: current and target pose with valid/ready handshake.
interface rfpc_pose_if;
  import rfpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [YAW_W-1:0]      cur_yaw;
  logic signed [COORD_BITS-1:0] goal_x;
  logic signed [COORD_BITS-1:0] goal_y;
  logic signed [YAW_W-1:0]      goal_yaw;

  modport source (
    output valid, cur_x, cur_y, cur_yaw, goal_x, goal_y, goal_yaw,
    input  ready
  );

  modport sink (
    input  valid, cur_x, cur_y, cur_yaw, goal_x, goal_y, goal_yaw,
    output ready
  );
endinterface

// File: rtl/rfpc_speed_if.sv
// Output channel: velocity command with valid/ready handshake.
interface rfpc_speed_if;
  import rfpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] speed_tangent;
  logic signed [OUT_W-1:0] speed_normal;
  logic signed [OUT_W-1:0] speed_turn;

  modport source (
    output valid, speed_tangent, speed_normal, speed_turn,
    input  ready
  );

  modport sink (
    input  valid, speed_tangent, speed_normal, speed_turn,
    output ready
  );
endinterface

// File: rtl/rfpc_regs.sv
// APB-style gain registers.
module rfpc_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rfpc_pkg::PADDR_W-1:0]         paddr,
  input  logic [rfpc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [rfpc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output rfpc_pkg::rfpc_cfg_t                  cfg_o
);
  import rfpc_pkg::*;

  rfpc_cfg_t             cfg_q, cfg_d;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_LINEAR_GAIN:  cfg_d.linear_gain  = pwdata[LIN_GAIN_W-1:0];
        REG_ANGULAR_GAIN: cfg_d.angular_gain = pwdata[ANG_GAIN_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.linear_gain  <= LIN_GAIN_RESET;
      cfg_q.angular_gain <= ANG_GAIN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_LINEAR_GAIN:  prdata = APB_DATA_W'(cfg_q.linear_gain);
      REG_ANGULAR_GAIN: prdata = APB_DATA_W'(cfg_q.angular_gain);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

// File: rtl/rfpc_cordic_cell.sv
// One CORDIC micro-rotation cell with its own valid bit and stall handling.
module rfpc_cordic_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rfpc_pkg::ATAN_IDX_W-1:0]   stage_i,
  input  logic                              up_valid_i,
  input  rfpc_pkg::rfpc_rot_t               up_data_i,
  output logic                              up_ready_o,
  output logic                              dn_valid_o,
  output rfpc_pkg::rfpc_rot_t               dn_data_o,
  input  logic                              dn_ready_i
);
  import rfpc_pkg::*;

  logic                  vld_q;
  rfpc_rot_t             data_q, data_d;
  logic signed [XY_W-1:0] sh_x, sh_y;
  logic signed [ZW-1:0]   ang;

  // cell takes new data when empty or when its content moves on
  assign up_ready_o = !vld_q || dn_ready_i;

  // rotate toward z = 0
  always_comb begin
    sh_x   = up_data_i.x >>> stage_i;
    sh_y   = up_data_i.y >>> stage_i;
    ang    = atan_q29(stage_i);
    data_d = up_data_i;
    if (!up_data_i.z[ZW-1]) begin
      data_d.x = up_data_i.x - sh_y;
      data_d.y = up_data_i.y + sh_x;
      data_d.z = up_data_i.z - ang;
    end else begin
      data_d.x = up_data_i.x + sh_y;
      data_d.y = up_data_i.y - sh_x;
      data_d.z = up_data_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (up_ready_o) begin
      vld_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = vld_q;
  assign dn_data_o  = data_q;
endmodule

// File: rtl/rfpc_scale.sv
// Output pipeline: sine/cosine rounding, frame rotation, gain scaling and saturation.
module rfpc_scale (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   up_valid_i,
  input  rfpc_pkg::rfpc_rot_t                    up_data_i,
  output logic                                   up_ready_o,
  input  logic [rfpc_pkg::LIN_GAIN_W-1:0]        linear_gain_i,
  output logic                                   dn_valid_o,
  input  logic                                   dn_ready_i,
  output logic signed [rfpc_pkg::OUT_W-1:0]      tangent_o,
  output logic signed [rfpc_pkg::OUT_W-1:0]      normal_o,
  output logic signed [rfpc_pkg::OUT_W-1:0]      turn_o
);
  import rfpc_pkg::*;

  localparam int NSTG     = 6;
  localparam int CS_SHIFT = 6;
  localparam int CS_W     = XY_W - CS_SHIFT;
  localparam int PROD_W   = ERR_W + CS_W;
  localparam int V_W      = PROD_W + 1;
  localparam int LO_W     = 24;
  localparam int HI_W     = V_W - LO_W;
  localparam int HIG_W    = HI_W + LIN_GAIN_W + 1;
  localparam int LOG_W    = LO_W + LIN_GAIN_W;
  localparam int SUM_W    = HIG_W + LO_W + 1;
  localparam int LIN_SHIFT = 32;
  localparam int RES_W    = SUM_W - LIN_SHIFT;
  localparam int SAT_W    = RES_W + OUT_W;

  localparam logic signed [XY_W-1:0]        CsRnd     = XY_W'(32);
  localparam logic signed [XY_W-1:0]        CsRndNeg  = XY_W'(33);
  localparam logic signed [TURN_PROD_W-1:0] TurnRnd   = TURN_PROD_W'(4096);
  localparam logic signed [SUM_W-1:0]       LinRnd    = SUM_W'(1) << (LIN_SHIFT - 1);
  localparam logic signed [SAT_W-1:0]       SatMax    = SAT_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [SAT_W-1:0]       SatMin    = ~SatMax;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [RES_W-1:0] v);
    logic signed [SAT_W-1:0] w;
    w = SAT_W'(v);
    if (w > SatMax) begin
      w = SatMax;
    end else if (w < SatMin) begin
      w = SatMin;
    end
    return w[OUT_W-1:0];
  endfunction

  // per-stage valid and ready chain
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_in;
  logic [NSTG:0]   rdy;

  assign vld_in = {vld_q[NSTG-2:0], up_valid_i};

  always_comb begin
    rdy[NSTG] = dn_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign up_ready_o = rdy[0];

  // stage 1: round cosine/sine to Q1.24 (with flip), round turn rate
  logic signed [XY_W-1:0]        x_sel, y_sel, x_rnd, y_rnd;
  logic signed [TURN_PROD_W-1:0] turn_rnd;
  logic signed [CS_W-1:0]        c_q, s_q;
  logic signed [ERR_W-1:0]       ex1_q, ey1_q;
  logic signed [OUT_W-1:0]       turn1_q;

  always_comb begin
    x_sel    = up_data_i.flip ? ~up_data_i.x : up_data_i.x;
    y_sel    = up_data_i.flip ? ~up_data_i.y : up_data_i.y;
    x_rnd    = x_sel + (up_data_i.flip ? CsRndNeg : CsRnd);
    y_rnd    = y_sel + (up_data_i.flip ? CsRndNeg : CsRnd);
    turn_rnd = up_data_i.turn_prod + TurnRnd;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      c_q     <= $signed(x_rnd[XY_W-1:CS_SHIFT]);
      s_q     <= $signed(y_rnd[XY_W-1:CS_SHIFT]);
      ex1_q   <= up_data_i.ex;
      ey1_q   <= up_data_i.ey;
      turn1_q <= OUT_W'($signed(turn_rnd[TURN_PROD_W-1:TURN_SHIFT]));
    end
  end

  // stage 2: four products of error and cosine/sine
  logic signed [PROD_W-1:0] p_xc_q, p_xs_q, p_yc_q, p_ys_q;
  logic signed [OUT_W-1:0]  turn2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      p_xc_q  <= ex1_q * c_q;
      p_xs_q  <= ex1_q * s_q;
      p_yc_q  <= ey1_q * c_q;
      p_ys_q  <= ey1_q * s_q;
      turn2_q <= turn1_q;
    end
  end

  // stage 3: rotated errors in Q.24 mm
  logic signed [V_W-1:0]   vt_q, vn_q;
  logic signed [OUT_W-1:0] turn3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      vt_q    <= V_W'(p_xc_q) + V_W'(p_ys_q);
      vn_q    <= V_W'(p_yc_q) - V_W'(p_xs_q);
      turn3_q <= turn2_q;
    end
  end

  // stage 4: gain product split into high and low partial products
  logic signed [LIN_GAIN_W:0] gain_s;
  logic signed [HIG_W-1:0]    vt_hi_q, vn_hi_q;
  logic [LOG_W-1:0]           vt_lo_q, vn_lo_q;
  logic signed [OUT_W-1:0]    turn4_q;

  assign gain_s = $signed({1'b0, linear_gain_i});

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      vt_hi_q <= $signed(vt_q[V_W-1:LO_W]) * gain_s;
      vn_hi_q <= $signed(vn_q[V_W-1:LO_W]) * gain_s;
      vt_lo_q <= vt_q[LO_W-1:0] * linear_gain_i;
      vn_lo_q <= vn_q[LO_W-1:0] * linear_gain_i;
      turn4_q <= turn3_q;
    end
  end

  // stage 5: recombine and add the rounding half
  logic signed [SUM_W-1:0] vt_sum_q, vn_sum_q;
  logic signed [OUT_W-1:0] turn5_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      vt_sum_q <= (SUM_W'(vt_hi_q) <<< LO_W) + SUM_W'($signed({1'b0, vt_lo_q})) + LinRnd;
      vn_sum_q <= (SUM_W'(vn_hi_q) <<< LO_W) + SUM_W'($signed({1'b0, vn_lo_q})) + LinRnd;
      turn5_q  <= turn4_q;
    end
  end

  // stage 6: drop to Q.16 and saturate; this is the output register
  logic signed [OUT_W-1:0] tan_q, nor_q, turn6_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      tan_q   <= sat_out($signed(vt_sum_q[SUM_W-1:LIN_SHIFT]));
      nor_q   <= sat_out($signed(vn_sum_q[SUM_W-1:LIN_SHIFT]));
      turn6_q <= turn5_q;
    end
  end

  assign dn_valid_o = vld_q[NSTG-1];
  assign tangent_o  = tan_q;
  assign normal_o   = nor_q;
  assign turn_o     = turn6_q;
endmodule

// File: rtl/robot_frame_p_control_unit.sv
// Top level of the robot-frame proportional controller.
// Stages: 1 entry stage, 16 CORDIC cells and 6 output stages from input transaction to result.
// Throughput: one pose pair per cycle while the output is not stalled; every stage has its own valid
// bit and ready ripples back from the output register, so bubbles close up under stall.
// Reset (rst_ni, async, active low) clears all valid bits and loads the default gains.
module robot_frame_p_control_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rfpc_pose_if.sink                          pose_i,
  rfpc_speed_if.source                       speed_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rfpc_pkg::PADDR_W-1:0]       paddr,
  input  logic [rfpc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rfpc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import rfpc_pkg::*;

  rfpc_cfg_t cfg;

  rfpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // entry stage: errors, turn product and quadrant fold of the yaw
  logic                    front_vld_q;
  rfpc_rot_t               front_q, front_d;
  logic signed [ZW-1:0]    z_raw;
  logic signed [DYAW_W-1:0] dyaw;
  logic                    cell_rdy [CORDIC_STAGES+1];
  logic                    cell_vld [CORDIC_STAGES+1];
  rfpc_rot_t               cell_dat [CORDIC_STAGES+1];
  logic                    front_rdy;

  assign front_rdy    = !front_vld_q || cell_rdy[0];
  assign pose_i.ready = front_rdy;

  always_comb begin
    z_raw             = ZW'(pose_i.cur_yaw) <<< YAW_SHIFT;
    dyaw              = DYAW_W'(pose_i.goal_yaw) - DYAW_W'(pose_i.cur_yaw);
    front_d.x         = CORDIC_INV_GAIN;
    front_d.y         = '0;
    front_d.ex        = ERR_W'(pose_i.goal_x) - ERR_W'(pose_i.cur_x);
    front_d.ey        = ERR_W'(pose_i.goal_y) - ERR_W'(pose_i.cur_y);
    front_d.turn_prod = dyaw * $signed({1'b0, cfg.angular_gain});
    // beyond a right angle: fold by pi, negate cos/sin at the end
    priority if (z_raw > ANG_HALF_PI) begin
      front_d.z    = z_raw - ANG_PI;
      front_d.flip = 1'b1;
    end else if (z_raw < -ANG_HALF_PI) begin
      front_d.z    = z_raw + ANG_PI;
      front_d.flip = 1'b1;
    end else begin
      front_d.z    = z_raw;
      front_d.flip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_vld_q <= 1'b0;
    end else if (front_rdy) begin
      front_vld_q <= pose_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_rdy) begin
      front_q <= front_d;
    end
  end

  // CORDIC cell chain
  assign cell_vld[0] = front_vld_q;
  assign cell_dat[0] = front_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    rfpc_cordic_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .stage_i    (ATAN_IDX_W'(i)),
      .up_valid_i (cell_vld[i]),
      .up_data_i  (cell_dat[i]),
      .up_ready_o (cell_rdy[i]),
      .dn_valid_o (cell_vld[i+1]),
      .dn_data_o  (cell_dat[i+1]),
      .dn_ready_i (cell_rdy[i+1])
    );
  end

  // rotation, gain and saturation pipeline
  rfpc_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .up_valid_i    (cell_vld[CORDIC_STAGES]),
    .up_data_i     (cell_dat[CORDIC_STAGES]),
    .up_ready_o    (cell_rdy[CORDIC_STAGES]),
    .linear_gain_i (cfg.linear_gain),
    .dn_valid_o    (speed_o.valid),
    .dn_ready_i    (speed_o.ready),
    .tangent_o     (speed_o.speed_tangent),
    .normal_o      (speed_o.speed_normal),
    .turn_o        (speed_o.speed_turn)
  );

`ifndef SYNTHESIS
  // an empty entry stage must always take a transaction
  a_front_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !front_vld_q |-> pose_i.ready)
    else $error("entry stage empty but input not ready");

  // an accepted transaction lands in the entry stage
  a_front_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_i.valid && pose_i.ready |=> front_vld_q)
    else $error("accepted transaction lost at entry stage");

  // linear gain write is visible on the next cycle
  a_gain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_LINEAR_GAIN)
    |=> cfg.linear_gain == $past(pwdata[LIN_GAIN_W-1:0]))
    else $error("linear gain write not applied");

  // turn rate never leaves its sign-extended range
  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_o.valid |-> (speed_o.speed_turn[OUT_W-1:TURN_W-1]
      == {(OUT_W-TURN_W+1){speed_o.speed_turn[OUT_W-1]}}))
    else $error("turn rate carried with corrupted upper bits");
`endif
endmodule
